FILE: hw/rtl/abip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abip_pkg: shared definitions for the AArch64 immediate patcher
// Encoding form codes, per-form keep masks and the address width in use.
// ----------------------------------------------------------------------------
package abip_pkg;

	// Low bits of each address taken part in the arithmetic (32 to 64).
	localparam int ADDR_WIDTH = 64;

	localparam int CMD_WIDTH  = 5;
	localparam int WORD_WIDTH = 32;
	localparam int PORT_ADDR_WIDTH = 64;

	typedef enum logic [CMD_WIDTH-1:0] {
		FORM_ADRP   = 5'd0,
		FORM_ADR    = 5'd1,
		FORM_ADD    = 5'd2,
		FORM_LDR    = 5'd3,
		FORM_LDRH   = 5'd4,
		FORM_LDRB   = 5'd5,
		FORM_LDRSW  = 5'd6,
		FORM_LDRSH  = 5'd7,
		FORM_LDRSB  = 5'd8,
		FORM_LDRLIT = 5'd9,
		FORM_MOVZ   = 5'd10,
		FORM_MOVK   = 5'd11,
		FORM_STR    = 5'd12,
		FORM_STRH   = 5'd13,
		FORM_STRB   = 5'd14,
		FORM_BL     = 5'd15,
		FORM_B      = 5'd16,
		FORM_BCOND  = 5'd17,
		FORM_CBZ    = 5'd18,
		FORM_CBNZ   = 5'd19,
		FORM_TBZ    = 5'd20,
		FORM_TBNZ   = 5'd21
	} form_t;

	localparam logic [WORD_WIDTH-1:0] MASK_ADRP   = 32'h9000_001F;
	localparam logic [WORD_WIDTH-1:0] MASK_ADR    = 32'h9F00_001F;
	localparam logic [WORD_WIDTH-1:0] MASK_ADD    = 32'hFFC0_03FF;
	localparam logic [WORD_WIDTH-1:0] MASK_LDST   = 32'hFFE0_03FF;
	localparam logic [WORD_WIDTH-1:0] MASK_IMM19  = 32'hFF00_001F;
	localparam logic [WORD_WIDTH-1:0] MASK_MOV    = 32'hFFE0_001F;
	localparam logic [WORD_WIDTH-1:0] MASK_BRANCH = 32'hFC00_0000;
	localparam logic [WORD_WIDTH-1:0] MASK_TEST   = 32'hFFF8_001F;
	localparam logic [WORD_WIDTH-1:0] MASK_NONE   = 32'hFFFF_FFFF;

	function automatic logic [WORD_WIDTH-1:0] form_mask(input form_t form);
		logic [WORD_WIDTH-1:0] m;
		unique case (form)
			FORM_ADRP: m = MASK_ADRP;
			FORM_ADR: m = MASK_ADR;
			FORM_ADD: m = MASK_ADD;
			FORM_LDR, FORM_LDRH, FORM_LDRB, FORM_LDRSW, FORM_LDRSH, FORM_LDRSB,
			FORM_STR, FORM_STRH, FORM_STRB: m = MASK_LDST;
			FORM_LDRLIT, FORM_BCOND, FORM_CBZ, FORM_CBNZ: m = MASK_IMM19;
			FORM_MOVZ, FORM_MOVK: m = MASK_MOV;
			FORM_BL, FORM_B: m = MASK_BRANCH;
			FORM_TBZ, FORM_TBNZ: m = MASK_TEST;
			default: m = MASK_NONE;
		endcase
		return m;
	endfunction

endpackage

FILE: hw/rtl/aarch64_branch_address_immediate_patch.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarch64_branch_address_immediate_patch: AArch64 immediate patcher
// Rewrites the immediate field of one instruction word to reach a target.
// ----------------------------------------------------------------------------
// Each transaction carries an instruction word, its encoding form and the
// source and target addresses; the block returns one transaction holding the
// word with its fixed bits kept and its immediate recomputed. Offsets that do
// not fit the field are truncated without notice, and unused form codes pass
// the word through unchanged. An accepted transaction passes through the input
// register, a short subtract-and-place path and the result register, which form
// the only pipeline; one transaction is taken per cycle while the output is not
// stalled. A stall on the output stops the result register first; the
// input register keeps taking work until it too is full.
module aarch64_branch_address_immediate_patch (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [abip_pkg::CMD_WIDTH-1:0]       cmd,
	input  logic [abip_pkg::WORD_WIDTH-1:0]      instr_word,
	input  logic [abip_pkg::PORT_ADDR_WIDTH-1:0] source_address,
	input  logic [abip_pkg::PORT_ADDR_WIDTH-1:0] target_address,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [abip_pkg::WORD_WIDTH-1:0]      patched_word
);

	// Stage 1: captured input transaction
	logic                                 valid_s1;
	logic [abip_pkg::CMD_WIDTH-1:0]       cmd_s1;
	logic [abip_pkg::WORD_WIDTH-1:0]      word_s1;
	logic [abip_pkg::PORT_ADDR_WIDTH-1:0] src_s1;
	logic [abip_pkg::PORT_ADDR_WIDTH-1:0] tgt_s1;

	// Stage 2: result register
	logic                                 valid_s2;
	logic [abip_pkg::WORD_WIDTH-1:0]      word_s2;

	logic [abip_pkg::WORD_WIDTH-1:0]      patched;
	logic                                 advance_s1;
	logic                                 load_s1;

	// Advance stage 1 whenever the result register is empty or being drained
	assign advance_s1 = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready   = !valid_s1 || advance_s1;
	assign load_s1    = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Hold payload unless a new transaction is taken
	always_ff @(posedge clk) begin
		if (load_s1) begin
			cmd_s1  <= cmd;
			word_s1 <= instr_word;
			src_s1  <= source_address;
			tgt_s1  <= target_address;
		end
	end

	abip_patch_core u_core (
		.cmd            (cmd_s1),
		.instr_word     (word_s1),
		.source_address (src_s1),
		.target_address (tgt_s1),
		.patched_word   (patched)
	);

	// Drop the result once taken; refill from stage 1 in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			word_s2 <= patched;
		end
	end

	assign out_valid    = valid_s2;
	assign patched_word = word_s2;

endmodule

FILE: hw/rtl/abip_patch_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abip_patch_core: immediate field rewrite
// Combinational: offset subtract, field placement and merge under the mask.
// ----------------------------------------------------------------------------
module abip_patch_core (
	input  logic [abip_pkg::CMD_WIDTH-1:0]       cmd,
	input  logic [abip_pkg::WORD_WIDTH-1:0]      instr_word,
	input  logic [abip_pkg::PORT_ADDR_WIDTH-1:0] source_address,
	input  logic [abip_pkg::PORT_ADDR_WIDTH-1:0] target_address,
	output logic [abip_pkg::WORD_WIDTH-1:0]      patched_word
);

	localparam int AW = abip_pkg::ADDR_WIDTH;

	abip_pkg::form_t                  form;
	logic [abip_pkg::WORD_WIDTH-1:0]  mask;
	logic [abip_pkg::WORD_WIDTH-1:0]  kept;
	logic [abip_pkg::WORD_WIDTH-1:0]  imm;
	logic [AW-1:0]                    src;
	logic [AW-1:0]                    tgt;
	logic [AW-1:0]                    diff_raw;
	logic [AW-1:0]                    page_raw;
	logic [32:0]                      diff;
	logic [32:0]                      page;
	logic [63:0]                      tgt_wide;
	logic [15:0]                      movk_half;
	logic [2:0]                       ld_scale;
	logic [11:0]                      low12;
	logic [11:0]                      low12_sh;
	logic [2:0]                       scale;

	assign form = abip_pkg::form_t'(cmd);
	assign mask = abip_pkg::form_mask(form);
	assign kept = instr_word & mask;

	assign src = source_address[AW-1:0];
	assign tgt = target_address[AW-1:0];

	// Wrap at the address width, then sign extend; only bit 32 and below matter.
	assign diff_raw = tgt - src;
	assign page_raw = tgt - {src[AW-1:12], 12'h000};
	assign diff     = 33'(signed'(diff_raw));
	assign page     = 33'(signed'(page_raw));

	assign tgt_wide = 64'(tgt);
	always_comb begin
		unique case (kept[22:21])
			2'd0: movk_half = tgt_wide[15:0];
			2'd1: movk_half = tgt_wide[31:16];
			2'd2: movk_half = tgt_wide[47:32];
			2'd3: movk_half = tgt_wide[63:48];
		endcase
	end

	// Access-size scale: bit 23 selects the 128-bit SIMD form
	assign ld_scale = {kept[23], kept[31:30]};

	always_comb begin
		unique case (form)
			abip_pkg::FORM_LDR, abip_pkg::FORM_STR: scale = ld_scale;
			abip_pkg::FORM_LDRH, abip_pkg::FORM_LDRSH, abip_pkg::FORM_STRH: scale = 3'd1;
			abip_pkg::FORM_LDRSW: scale = 3'd2;
			default: scale = 3'd0;
		endcase
	end

	assign low12    = tgt[11:0];
	assign low12_sh = low12 >> scale;

	always_comb begin
		unique case (form)
			abip_pkg::FORM_ADRP:
				imm = {1'b0, page[13:12], 5'b0, page[32:14], 5'b0};
			abip_pkg::FORM_ADR:
				imm = {1'b0, diff[1:0], 5'b0, diff[20:2], 5'b0};
			abip_pkg::FORM_ADD, abip_pkg::FORM_LDR, abip_pkg::FORM_LDRH,
			abip_pkg::FORM_LDRB, abip_pkg::FORM_LDRSW, abip_pkg::FORM_LDRSH,
			abip_pkg::FORM_LDRSB, abip_pkg::FORM_STR, abip_pkg::FORM_STRH,
			abip_pkg::FORM_STRB:
				imm = {10'b0, low12_sh, 10'b0} & ~mask;
			abip_pkg::FORM_LDRLIT, abip_pkg::FORM_BCOND, abip_pkg::FORM_CBZ,
			abip_pkg::FORM_CBNZ, abip_pkg::FORM_TBZ, abip_pkg::FORM_TBNZ:
				imm = {8'b0, diff[20:2], 5'b0} & ~mask;
			abip_pkg::FORM_MOVZ:
				imm = {11'b0, tgt_wide[15:0], 5'b0};
			abip_pkg::FORM_MOVK:
				imm = {11'b0, movk_half, 5'b0};
			abip_pkg::FORM_BL, abip_pkg::FORM_B:
				imm = {6'b0, diff[27:2]};
			default:
				imm = '0;
		endcase
	end

	assign patched_word = kept | imm;

endmodule

FILE: hw/rtl/abip_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abip_checker: port-level checks for the immediate patcher
// Watches the top-level handshakes only; attached by bind.
// ----------------------------------------------------------------------------
module abip_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [abip_pkg::WORD_WIDTH-1:0] patched_word
);

	// Stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(patched_word))
		else $error("result changed or dropped while stalled");

	// With the output side empty the input side must be open
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked while output empty");

	// A transaction taken into an empty pipe shows up after the input and result registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |-> ##2 out_valid)
		else $error("result missing after two cycles");

endmodule

bind aarch64_branch_address_immediate_patch abip_checker u_abip_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.patched_word (patched_word)
);

FILE: tb/tb_aarch64_branch_address_immediate_patch.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aarch64_branch_address_immediate_patch: self-checking bench for the patcher
// Drives instruction words, forms and address pairs through the valid/ready
// input, and checks every returned word against a typed-in answer or a local
// re-encoding model, under several idling patterns and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_aarch64_branch_address_immediate_patch;

	// Form codes that the block leaves unused: the word must pass untouched.
	localparam logic [abip_pkg::CMD_WIDTH-1:0] FORM_SPARE_FIRST = 5'd22;
	localparam logic [abip_pkg::CMD_WIDTH-1:0] FORM_SPARE_LAST  = 5'd31;

	localparam int          NUM_DIRECTED = 26;
	localparam int          RANDOM_ITEMS = 1550;
	localparam int          CYCLE_LIMIT  = 100_000;
	localparam logic [63:0] ADDR_KEEP    = {64{1'b1}} >> (64 - abip_pkg::ADDR_WIDTH);
	localparam logic [63:0] PAGE_LOW     = 64'hFFF;

	// One transaction of stimulus; known marks a row whose answer is typed in.
	typedef struct packed {
		logic [abip_pkg::CMD_WIDTH-1:0]  cmd;
		logic [abip_pkg::WORD_WIDTH-1:0] word;
		logic [63:0]                     src;
		logic [63:0]                     tgt;
		logic                            known;
		logic [abip_pkg::WORD_WIDTH-1:0] patched;
	} patch_case_t;

	logic                                 clk            = 1'b0;
	logic                                 arst_n         = 1'b0;
	logic                                 in_valid       = 1'b0;
	logic                                 in_ready;
	logic [abip_pkg::CMD_WIDTH-1:0]       cmd            = '0;
	logic [abip_pkg::WORD_WIDTH-1:0]      instr_word     = '0;
	logic [abip_pkg::PORT_ADDR_WIDTH-1:0] source_address = '0;
	logic [abip_pkg::PORT_ADDR_WIDTH-1:0] target_address = '0;
	logic                                 out_valid;
	logic                                 out_ready      = 1'b0;
	logic [abip_pkg::WORD_WIDTH-1:0]      patched_word;

	// Side information travelling with the payload on the input port.
	logic                                 cur_known      = 1'b0;
	logic [abip_pkg::WORD_WIDTH-1:0]      cur_patched    = '0;

	patch_case_t                          patch_requests[$];
	logic [abip_pkg::WORD_WIDTH-1:0]      patched_expected[$];
	int unsigned                          send_idle_pct  = 0;
	int unsigned                          recv_stall_pct = 0;
	int unsigned                          accepted_in    = 0;
	int unsigned                          accepted_out   = 0;
	int unsigned                          mismatch_count = 0;
	int unsigned                          cycle_count    = 0;
	int unsigned                          holdoff_left   = 0;
	bit                                   holdoff_done   = 1'b0;
	bit                                   sender_done    = 1'b0;

	// Directed rows: extremes, every form, the scaled SIMD offsets, MOVK
	// halfword selection, wrapped and truncated offsets, and the unused codes.
	patch_case_t directed_cases [NUM_DIRECTED] = '{
		'{abip_pkg::FORM_ADRP, 32'h9000_0000, 64'h0000_0000_0000_1000,
			64'h0000_0000_0000_1000, 1'b1, 32'h9000_0000},
		'{abip_pkg::FORM_ADRP, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_F123,
			64'h0000_0000_0001_2345, 1'b0, 32'h0},
		'{abip_pkg::FORM_ADR, 32'h1000_0000, 64'h0,
			64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'h0},
		'{abip_pkg::FORM_ADD, 32'h9100_0000, 64'h0,
			64'h0000_0000_0000_0FFF, 1'b1, 32'h913F_FC00},
		'{abip_pkg::FORM_LDR, 32'hF940_0000, 64'h0,
			64'h0000_0000_0000_0FF8, 1'b0, 32'h0},
		'{abip_pkg::FORM_LDR, 32'h3DC0_0000, 64'h0,
			64'h0000_0000_0000_0FF0, 1'b0, 32'h0},
		'{abip_pkg::FORM_LDRH, 32'h7940_0000, 64'h0,
			64'h0000_0000_0000_07FE, 1'b0, 32'h0},
		'{abip_pkg::FORM_LDRB, 32'h3940_0000, 64'h0,
			64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'h0},
		'{abip_pkg::FORM_LDRSW, 32'hB980_0000, 64'h0,
			64'h0000_0000_0000_0FFC, 1'b0, 32'h0},
		'{abip_pkg::FORM_LDRSH, 32'h79C0_0000, 64'h0,
			64'h0000_0000_0000_0ABE, 1'b0, 32'h0},
		'{abip_pkg::FORM_LDRSB, 32'h39C0_0000, 64'h0,
			64'h0000_0000_0000_0001, 1'b0, 32'h0},
		'{abip_pkg::FORM_LDRLIT, 32'h5800_0000, 64'h0000_0000_0010_0000,
			64'h0000_0020_0000_0000, 1'b0, 32'h0},
		'{abip_pkg::FORM_MOVZ, 32'hD280_0000, 64'h0,
			64'h0000_0000_0000_FFFF, 1'b1, 32'hD29F_FFE0},
		'{abip_pkg::FORM_MOVK, 32'hF2E0_0000, 64'h0,
			64'hFEDC_BA98_7654_3210, 1'b0, 32'h0},
		'{abip_pkg::FORM_STR, 32'h3D80_0000, 64'h0,
			64'h0000_0000_0000_0FF0, 1'b0, 32'h0},
		'{abip_pkg::FORM_STRH, 32'h7900_0000, 64'h0,
			64'h0000_0000_0000_0002, 1'b0, 32'h0},
		'{abip_pkg::FORM_STRB, 32'h3900_0000, 64'h0,
			64'h0000_0000_0000_0FFF, 1'b0, 32'h0},
		'{abip_pkg::FORM_BL, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFC,
			64'hFFFF_FFFF_FFFF_FFFC, 1'b1, 32'hFC00_0000},
		'{abip_pkg::FORM_B, 32'h1400_0000, 64'h0000_0000_0000_0004,
			64'h0, 1'b1, 32'h17FF_FFFF},
		'{abip_pkg::FORM_BCOND, 32'h5400_0000, 64'h0000_0000_0000_4000,
			64'h8000_0000_0000_4000, 1'b0, 32'h0},
		'{abip_pkg::FORM_CBZ, 32'hB400_0000, 64'h0000_0000_0000_0100,
			64'h0000_0000_0000_00FC, 1'b1, 32'hB4FF_FFE0},
		'{abip_pkg::FORM_CBNZ, 32'hB500_0000, 64'h0,
			64'h0000_0000_000F_FFFC, 1'b0, 32'h0},
		'{abip_pkg::FORM_TBZ, 32'h3600_0000, 64'h0000_0000_0000_1000,
			64'h0, 1'b0, 32'h0},
		'{abip_pkg::FORM_TBNZ, 32'hB7FF_FFFF, 64'h0000_0000_0000_2000,
			64'h0000_0000_0000_9FFC, 1'b0, 32'h0},
		'{FORM_SPARE_FIRST, 32'h1234_5678, 64'h0000_0000_0000_0000,
			64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'h1234_5678},
		'{FORM_SPARE_LAST, 32'hDEAD_BEEF, 64'hFFFF_FFFF_FFFF_FFFF,
			64'h0, 1'b1, 32'hDEAD_BEEF}
	};

	aarch64_branch_address_immediate_patch i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.cmd            (cmd),
		.instr_word     (instr_word),
		.source_address (source_address),
		.target_address (target_address),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.patched_word   (patched_word)
	);

	always #1 clk = ~clk;

	// Target minus source, wrapped to the address width and sign-extended.
	function automatic logic [63:0] pc_delta(input logic [63:0] tgt, input logic [63:0] src);
		logic [63:0] d;
		d = (tgt - src) & ADDR_KEEP;
		if (abip_pkg::ADDR_WIDTH < 64 && d[abip_pkg::ADDR_WIDTH-1])
			d = d | ~ADDR_KEEP;
		return d;
	endfunction

	// Split an offset into ADR's immlo (bits 30:29) and immhi (bits 23:5).
	function automatic logic [31:0] adr_imm(input logic [63:0] v);
		return {1'b0, v[1:0], 29'b0} | {8'b0, v[20:2], 5'b0};
	endfunction

	// Page offset of the target, scaled down by the access size into imm12.
	function automatic logic [31:0] scaled_low12(input logic [63:0] tgt, input logic [2:0] scale,
			input logic [31:0] keep_mask);
		logic [31:0] off;
		off = {20'b0, tgt[11:0]} >> scale;
		return (off << 10) & ~keep_mask;
	endfunction

	// Re-encode one instruction word so that it reaches the target.
	function automatic logic [31:0] relocate_word(input logic [abip_pkg::CMD_WIDTH-1:0] code,
			input logic [31:0] word, input logic [63:0] src_in, input logic [63:0] tgt_in);
		logic [63:0] src;
		logic [63:0] tgt;
		logic [63:0] d;
		logic [63:0] half;
		logic [31:0] keep_mask;
		logic [31:0] kept;
		logic [31:0] imm;
		src = src_in & ADDR_KEEP;
		tgt = tgt_in & ADDR_KEEP;
		d   = pc_delta(tgt, src);
		imm = '0;
		case (code)
			abip_pkg::FORM_ADRP: keep_mask = abip_pkg::MASK_ADRP;
			abip_pkg::FORM_ADR: keep_mask = abip_pkg::MASK_ADR;
			abip_pkg::FORM_ADD: keep_mask = abip_pkg::MASK_ADD;
			abip_pkg::FORM_LDR, abip_pkg::FORM_LDRH, abip_pkg::FORM_LDRB,
			abip_pkg::FORM_LDRSW, abip_pkg::FORM_LDRSH, abip_pkg::FORM_LDRSB,
			abip_pkg::FORM_STR, abip_pkg::FORM_STRH, abip_pkg::FORM_STRB:
				keep_mask = abip_pkg::MASK_LDST;
			abip_pkg::FORM_LDRLIT, abip_pkg::FORM_BCOND, abip_pkg::FORM_CBZ,
			abip_pkg::FORM_CBNZ:
				keep_mask = abip_pkg::MASK_IMM19;
			abip_pkg::FORM_MOVZ, abip_pkg::FORM_MOVK: keep_mask = abip_pkg::MASK_MOV;
			abip_pkg::FORM_BL, abip_pkg::FORM_B: keep_mask = abip_pkg::MASK_BRANCH;
			abip_pkg::FORM_TBZ, abip_pkg::FORM_TBNZ: keep_mask = abip_pkg::MASK_TEST;
			default: keep_mask = abip_pkg::MASK_NONE;
		endcase
		kept = word & keep_mask;
		case (code)
			abip_pkg::FORM_ADRP: imm = adr_imm(pc_delta(tgt, src & ~PAGE_LOW) >> 12);
			abip_pkg::FORM_ADR: imm = adr_imm(d);
			abip_pkg::FORM_ADD, abip_pkg::FORM_LDRB, abip_pkg::FORM_LDRSB,
			abip_pkg::FORM_STRB:
				imm = scaled_low12(tgt, 3'd0, keep_mask);
			// size from bits 31:30, plus four for the 128-bit SIMD register form
			abip_pkg::FORM_LDR, abip_pkg::FORM_STR:
				imm = scaled_low12(tgt, {kept[23], kept[31:30]}, keep_mask);
			abip_pkg::FORM_LDRH, abip_pkg::FORM_LDRSH, abip_pkg::FORM_STRH:
				imm = scaled_low12(tgt, 3'd1, keep_mask);
			abip_pkg::FORM_LDRSW: imm = scaled_low12(tgt, 3'd2, keep_mask);
			abip_pkg::FORM_LDRLIT: imm = {8'b0, d[20:2], 5'b0} & ~keep_mask;
			abip_pkg::FORM_MOVZ: imm = {11'b0, tgt[15:0], 5'b0};
			abip_pkg::FORM_MOVK: begin
				half = tgt >> (32'(kept[22:21]) * 16);
				imm  = {11'b0, half[15:0], 5'b0};
			end
			abip_pkg::FORM_BL, abip_pkg::FORM_B: imm = d[33:2] & ~keep_mask;
			abip_pkg::FORM_BCOND, abip_pkg::FORM_CBZ, abip_pkg::FORM_CBNZ,
			abip_pkg::FORM_TBZ, abip_pkg::FORM_TBNZ:
				imm = {d[28:2], 5'b0} & ~keep_mask;
			default: imm = '0;
		endcase
		return kept | imm;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: %s: expected %08h, got %08h", $realtime, what, want, got);
	endtask

	// Build the stimulus, apply reset, then wait for the last result to drain.
	initial begin : main
		patch_case_t req;
		logic [31:0] rnd;
		logic [63:0] off;
		foreach (directed_cases[i])
			patch_requests.push_back(directed_cases[i]);
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			rnd        = $urandom;
			req.known  = 1'b0;
			req.patched = '0;
			// mostly real forms; a few spare codes to check the pass-through
			if ($urandom_range(15) == 0)
				req.cmd = 5'($urandom_range(FORM_SPARE_LAST, FORM_SPARE_FIRST));
			else
				req.cmd = 5'($urandom_range(abip_pkg::FORM_TBNZ));
			req.word = $urandom;
			req.src  = {$urandom, $urandom};
			case ($urandom_range(3))
				0: req.tgt = {$urandom, $urandom};
				1: begin
					// near target: signed offsets of every magnitude up to 32 bits
					off     = {{32{rnd[31]}}, rnd};
					off     = $signed(off) >>> $urandom_range(31);
					req.tgt = req.src + off;
				end
				2: req.tgt = {52'(req.src[63:12] + 52'($signed(rnd[7:0]))), rnd[19:8]};
				default: req.tgt = ($urandom_range(1) == 0) ? ~req.src :
					{64{rnd[0]}} ^ {63'b0, rnd[1]};
			endcase
			patch_requests.push_back(req);
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted_out < patch_requests.size())
			@(posedge clk);
		// wait on, so that any stray result from the pipeline is seen
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && patched_expected.size() == 0)
			$display("tb_aarch64_branch_address_immediate_patch passed");
		else
			$display("tb_aarch64_branch_address_immediate_patch failed");
		$finish;
	end

	// Sender: offer the next transaction when the port is free and no idle gap is
	// drawn, holding valid and payload steady until the block takes it.
	initial begin : sender
		int next_idx;
		int r;
		next_idx = 0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		while (!sender_done) begin
			@(posedge clk);
			// idling phases: none, sender gaps, receiver stalls, then both lightly
			r = next_idx - NUM_DIRECTED;
			send_idle_pct  = (r >= 300 && r < 700) ? 58 : (r >= 1100) ? 9 : 0;
			recv_stall_pct = (r >= 700 && r < 1100) ? 58 : (r >= 1100) ? 9 : 0;
			if (!in_valid || in_ready) begin
				if (next_idx < patch_requests.size() &&
						$urandom_range(99) >= send_idle_pct) begin
					in_valid       <= 1'b1;
					cmd            <= patch_requests[next_idx].cmd;
					instr_word     <= patch_requests[next_idx].word;
					source_address <= patch_requests[next_idx].src;
					target_address <= patch_requests[next_idx].tgt;
					cur_known      <= patch_requests[next_idx].known;
					cur_patched    <= patch_requests[next_idx].patched;
					next_idx++;
				end else begin
					in_valid <= 1'b0;
					if (next_idx == patch_requests.size())
						sender_done = 1'b1;
				end
			end
		end
	end

	// Receiver: random stalls, and one long hold-off early in the unthrottled
	// phase so that the block fills up and pushes back on its input.
	always @(posedge clk) begin : receiver
		if (!holdoff_done && accepted_in >= NUM_DIRECTED + 100) begin
			holdoff_left = 60;
			holdoff_done = 1'b1;
		end
		if (holdoff_left > 0) begin
			holdoff_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Monitor: log the expected word for each input transaction taken, then
	// compare each output transaction with the oldest entry.
	always @(posedge clk) begin : monitor
		logic [abip_pkg::WORD_WIDTH-1:0] want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				accepted_in++;
				if (cur_known)
					patched_expected.push_back(cur_patched);
				else
					patched_expected.push_back(relocate_word(cmd, instr_word,
						source_address, target_address));
			end
			if (out_valid && out_ready) begin
				accepted_out++;
				if (patched_expected.size() == 0) begin
					report_mismatch("result with nothing outstanding", 'x, patched_word);
				end else begin
					want = patched_expected.pop_front();
					if (patched_word !== want)
						report_mismatch("patched_word mismatch", want, patched_word);
				end
			end
		end
	end

	// Watchdog: fail the run once it reaches the cycle limit.
	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_aarch64_branch_address_immediate_patch failed");
			$finish;
		end
	end

endmodule

FILE: files.f
hw/rtl/abip_pkg.sv
hw/rtl/abip_patch_core.sv
hw/rtl/aarch64_branch_address_immediate_patch.sv
hw/rtl/abip_checker.sv
tb/tb_aarch64_branch_address_immediate_patch.sv
